FILE: rtl/mpts_pkg.sv
// package for the multi-policy task selector
// shared constants; no dependencies
package mpts_pkg;

  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING  = 3'd4;
  localparam logic [2:0] PRIO_RESET  = 3'd3;
  localparam logic [2:0] LEVEL_LIMIT = 3'd6;

  localparam logic [2:0] POL_RR0     = 3'd0;
  localparam logic [2:0] POL_RR1     = 3'd1;
  localparam logic [2:0] POL_PRIO    = 3'd2;
  localparam logic [2:0] POL_LEVEL   = 3'd3;
  localparam logic [2:0] POL_LOTTERY = 3'd4;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_SEED   = 1'b1;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  localparam logic [31:0] LCG_MUL   = 32'd214013;
  localparam logic [31:0] LCG_ADD   = 32'd2531011;

endpackage

FILE: rtl/mpts_ram.sv
// generic single-port ram with registered read
// no dependencies
module mpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // registered read, returns old data on a write to the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/multi_policy_task_selector.sv
// multi-policy task selector top level
// depends on mpts_pkg and mpts_ram
// Each start word gives exactly one result word, marked by done for one cycle; the receiver
// cannot stall it. busy is high from acceptance until done. After reset a clearing pass
// writes every slot entry; busy stays high meanwhile. A write word passes through a write
// state and a done state. A select word reads the slot table through its single memory port
// one entry a cycle: round robin and priority scan it once, multilevel twice (once when no
// slot qualifies) and lottery twice (once with no tickets), lottery adding a bit-serial
// 15-bit remainder unit and a generator step between its scans.
module multi_policy_task_selector #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [5:0]  slot,
  input  logic [2:0]  new_state,
  input  logic [2:0]  new_priority,
  output logic        done,
  output logic        found,
  output logic [5:0]  chosen_slot,
  output logic [2:0]  chosen_priority,
  output logic [14:0] drawn_number,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import mpts_pkg::*;

  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int TW = AW + 3;  // ticket total width
  localparam logic [AW:0] LAST = (AW+1)'(TABLE_SLOTS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_SCAN, S_SCAN2, S_GEN, S_MOD, S_SCAN3,
    S_UPDATE, S_DONE
  } state_t;

  state_t          state;
  logic [2:0]      policy;
  logic [31:0]     gen;
  logic [AW-1:0]   rr_ptr;

  // memory port
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [5:0]      mem_wdata, mem_rdata;

  // scan bookkeeping
  logic [AW:0]     cnt;         // issued reads
  logic            rd_valid;    // read data present this cycle
  logic [AW-1:0]   rd_idx;
  logic            best_ok;
  logic [AW-1:0]   best_idx;
  logic [2:0]      best_pri;
  logic [2:0]      level;
  logic [TW-1:0]   total, passed;
  logic [14:0]     win, draw;
  logic [TW-1:0]   rem;
  logic [4:0]      bitc;
  logic [1:0]      gph;
  logic [31:0]     gprod;
  logic [AW-1:0]   req_slot;
  logic [5:0]      req_entry;
  logic            req_ok;

  mpts_ram #(.WIDTH(6), .DEPTH(1 << AW)) u_table (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  wire [2:0]  rd_st  = mem_rdata[5:3];
  wire [2:0]  rd_pr  = mem_rdata[2:0];
  wire        rd_run = rd_st == ST_RUNNABLE;
  wire [AW:0] rr_sum = {1'b0, rr_ptr} + cnt;
  wire [AW-1:0] rr_idx = (rr_sum > LAST) ? AW'(rr_sum - (LAST + 1'b1)) : rr_sum[AW-1:0];
  wire [AW:0] nxt_sum = {1'b0, best_idx} + 1'b1;
  wire [AW-1:0] nxt_ptr = (nxt_sum > LAST) ? '0 : nxt_sum[AW-1:0];
  wire        is_rr  = (policy == POL_RR0) || (policy == POL_RR1);
  wire        cyclic = is_rr || (policy == POL_LEVEL);
  wire [TW:0] rem_sh = {rem, win[14]};
  wire [TW:0] rem_sub = rem_sh - {1'b0, total};

  assign busy = state != S_IDLE;

  // memory address and write mux
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = req_entry;
    mem_addr  = cnt[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {3'd0, PRIO_RESET};
      end
      S_WRITE: begin
        mem_we   = req_ok;
        mem_addr = req_slot;
      end
      S_SCAN, S_SCAN2: mem_addr = cyclic ? rr_idx : cnt[AW-1:0];
      S_SCAN3: mem_addr = cnt[AW-1:0];
      S_UPDATE: begin
        mem_we    = best_ok;
        mem_addr  = best_idx;
        mem_wdata = {ST_RUNNING, best_pri};
      end
      default: ;
    endcase
  end

  // control sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      policy <= POL_RR1;
      gen    <= '0;
      rr_ptr <= '0;
      cnt    <= '0;
      done   <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_POLICY) begin
          if (cfg_data[2:0] <= POL_LOTTERY) policy <= cfg_data[2:0];
        end else begin
          gen <= cfg_data;
        end
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_slot  <= AW'(slot);
            req_ok    <= {3'b0, slot} < 9'(TABLE_SLOTS);
            req_entry <= {new_state, new_priority};
            cnt       <= '0;
            rd_valid  <= 1'b0;
            best_ok   <= 1'b0;
            best_idx  <= '0;
            best_pri  <= '0;
            level     <= LEVEL_LIMIT;
            total     <= '0;
            passed    <= '0;
            draw      <= '0;
            state     <= (mode == MODE_WRITE) ? S_WRITE : S_SCAN;
          end
        end
        S_WRITE: begin
          found           <= 1'b0;
          chosen_slot     <= '0;
          chosen_priority <= '0;
          drawn_number    <= '0;
          state           <= S_DONE;
        end
        // first pass: rr pick, priority pick, lowest level, ticket total
        S_SCAN: begin
          rd_valid <= cnt <= LAST;
          rd_idx   <= mem_addr;
          if (cnt <= LAST) cnt <= cnt + 1'b1;
          if (rd_valid && rd_run) begin
            total <= total + TW'(rd_pr);
            if (is_rr) begin
              if (!best_ok) begin
                best_ok <= 1'b1; best_idx <= rd_idx; best_pri <= rd_pr;
              end
            end else if (policy == POL_PRIO) begin
              if (!best_ok || rd_pr < best_pri) begin
                best_ok <= 1'b1; best_idx <= rd_idx; best_pri <= rd_pr;
              end
            end else if (rd_pr < level) begin
              level <= rd_pr;
            end
          end
          if (!rd_valid && cnt > LAST) begin
            cnt <= '0;
            if (policy == POL_LEVEL && level < LEVEL_LIMIT) state <= S_SCAN2;
            else if (policy == POL_LOTTERY && total != '0) begin
              gph   <= '0;
              state <= S_GEN;
            end else state <= S_UPDATE;
          end
        end
        // multilevel: cyclic scan for first slot at lowest level
        S_SCAN2: begin
          rd_valid <= cnt <= LAST;
          rd_idx   <= mem_addr;
          if (cnt <= LAST) cnt <= cnt + 1'b1;
          if (rd_valid && rd_run && rd_pr == level && !best_ok) begin
            best_ok <= 1'b1; best_idx <= rd_idx; best_pri <= rd_pr;
          end
          if (!rd_valid && cnt > LAST) begin
            cnt   <= '0;
            state <= S_UPDATE;
          end
        end
        // generator step split into three 16-bit partial products
        S_GEN: begin
          gph <= gph + 1'b1;
          unique case (gph)
            2'd0: gprod <= gen[15:0] * LCG_MUL[15:0];
            2'd1: gprod <= gprod + {(gen[31:16] * LCG_MUL[15:0]) , 16'd0};
            2'd2: gprod <= gprod + {(gen[15:0] * LCG_MUL[31:16]), 16'd0};
            default: begin
              gen   <= gprod + LCG_ADD;
              draw  <= 15'((gprod + LCG_ADD) >> 16);
              win   <= 15'((gprod + LCG_ADD) >> 16);
              rem   <= '0;
              bitc  <= '0;
              state <= S_MOD;
            end
          endcase
        end
        // bit-serial remainder of drawn number by ticket total
        S_MOD: begin
          win  <= {win[13:0], 1'b0};
          bitc <= bitc + 1'b1;
          rem  <= rem_sub[TW] ? rem_sh[TW-1:0] : rem_sub[TW-1:0];
          if (bitc == 5'd14) begin
            state <= S_SCAN3;
          end
        end
        // lottery cumulative scan
        S_SCAN3: begin
          rd_valid <= cnt <= LAST;
          rd_idx   <= mem_addr;
          if (cnt <= LAST) cnt <= cnt + 1'b1;
          if (rd_valid && rd_run && !best_ok) begin
            passed <= passed + TW'(rd_pr);
            if (passed + TW'(rd_pr) > rem) begin
              best_ok <= 1'b1; best_idx <= rd_idx; best_pri <= rd_pr;
            end
          end
          if (!rd_valid && cnt > LAST) begin
            cnt   <= '0;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (best_ok && cyclic) rr_ptr <= nxt_ptr;
          found           <= best_ok;
          chosen_slot     <= best_ok ? 6'(best_idx) : '0;
          chosen_priority <= best_ok ? best_pri : '0;
          drawn_number    <= draw;
          state           <= S_DONE;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // policy register never holds an unused code
  a_policy: assert property (@(posedge clk) disable iff (rst) policy <= POL_LOTTERY)
    else $error("policy out of range");
  // done only after the sequencer passes through its final state
  a_done: assert property (@(posedge clk) disable iff (rst) done |-> $past(state == S_DONE))
    else $error("done without completion");
  // a reported pick lies in the table
  a_slot: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> ({3'b0, chosen_slot} < 9'(TABLE_SLOTS)))
    else $error("chosen slot outside table");
  // no pick means all fields zero apart from the draw
  a_none: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (chosen_slot == '0 && chosen_priority == '0))
    else $error("empty pick carries data");
endmodule
